// ===== rtl/alte_pkg.sv =====
// Shared types and constants for the array list table engine.
package alte_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 4;
    localparam int CNT_W     = 5;
    localparam int ST_W      = 2;
    localparam int MAX_SLOTS = 16;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;
    localparam logic [CNT_W-1:0] NONE_IDX  = 5'h1F;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_SEARCH = 3'd4,
        OP_POP    = 3'd5
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RD_POS      = 3'd0,
        RD_LAST     = 3'd1,
        RD_POS_INC  = 3'd2,
        RD_ZERO     = 3'd3,
        RD_IDX_INC  = 3'd4,
        RD_IDX_INC2 = 3'd5
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_TAIL  = 2'd1,
        WR_POS   = 2'd2,
        WR_SHIFT = 2'd3
    } wr_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD = 2'd0,
        IDX_POS  = 2'd1,
        IDX_ZERO = 2'd2,
        IDX_INC  = 2'd3
    } idx_sel_t;

    typedef struct packed {
        logic     load_item;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        idx_sel_t idx_sel;
        logic     inc_count;
        logic     dec_count;
        logic     set_status;
        status_t  status_code;
        logic     cap_data;
        logic     set_found;
        logic     publish;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    pos_bad;
        logic    empty;
        logic    rm_tail;
        logic    shift_last;
        logic    search_hit;
        logic    search_last;
        logic    out_free;
    } flags_t;

endpackage

// ===== rtl/array_list_table_engine_unit.sv =====
// Top level of the array list table engine: bounded word list with linear search.
//
//  Channel   Ports                                            Direction
//  --------  -----------------------------------------------  ---------
//  config    cfg_wr_en, cfg_wr_data (capacity)                 in
//  item      s_valid/s_ready, s_opcode, s_position, s_value    in
//  result    m_valid/m_ready, m_data_out, m_found_index,       out
//            m_entry_count, m_status
//
// One word is handled at a time. Each operation passes from the accepting idle
// state through an execute state to a done state. Unless a check fails, read and
// pop add a read-wait state, remove before the tail adds a shift state that moves
// each later entry in turn, and search of a non-empty list adds a search state
// that compares entries until a hit or the last one. The done state waits until
// the output register is free and then loads it. The shift and the search walk
// the entry RAM one address per cycle through its single registered read port.
// Reset is synchronous and active low; it empties the list and restores a
// capacity of ten, while the entry RAM itself keeps whatever it held.
// The result sits in an output register. While m_ready holds it there, the
// next finished word waits in the controller, and the item side is not ready
// again until that word has moved into the output register.
module array_list_table_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic        [alte_pkg::CNT_W-1:0]  cfg_wr_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [alte_pkg::OP_W-1:0]   s_opcode,
    input  logic        [alte_pkg::POS_W-1:0]  s_position,
    input  logic signed [alte_pkg::DATA_W-1:0] s_value,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [alte_pkg::DATA_W-1:0] m_data_out,
    output logic signed [alte_pkg::CNT_W-1:0]  m_found_index,
    output logic        [alte_pkg::CNT_W-1:0]  m_entry_count,
    output logic        [alte_pkg::ST_W-1:0]   m_status
);

    // Commands flow from the controller to the datapath, and the datapath
    // reports comparisons and the output register's state back.
    alte_pkg::cmd_t   cmd;
    alte_pkg::flags_t flags;

    // The controller decides, per cycle, which address the RAM reads, which
    // entry it writes, and when the count and the result fields change.
    alte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    // The datapath holds the entries, the count, the capacity register and the
    // output word. Only the first min(DEPTH, 16) entries can ever be addressed.
    alte_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_opcode      (s_opcode),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_found_index (m_found_index),
        .m_entry_count (m_entry_count),
        .m_status      (m_status),
        .cmd           (cmd),
        .flags         (flags)
    );

endmodule

// ===== rtl/alte_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module alte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/alte_ctrl.sv =====
// Controller state machine that sequences each list operation.
module alte_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  alte_pkg::flags_t      flags,
    output alte_pkg::cmd_t        cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_RDWAIT = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_SEARCH = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd.load_item   = 1'b0;
        cmd.rd_sel      = alte_pkg::RD_POS;
        cmd.wr_sel      = alte_pkg::WR_NONE;
        cmd.idx_sel     = alte_pkg::IDX_HOLD;
        cmd.inc_count   = 1'b0;
        cmd.dec_count   = 1'b0;
        cmd.set_status  = 1'b0;
        cmd.status_code = alte_pkg::ST_OK;
        cmd.cap_data    = 1'b0;
        cmd.set_found   = 1'b0;
        cmd.publish     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (flags.op)
                    alte_pkg::OP_APPEND: begin
                        if (flags.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = alte_pkg::ST_FULL;
                        end else begin
                            cmd.wr_sel    = alte_pkg::WR_TAIL;
                            cmd.inc_count = 1'b1;
                        end
                    end
                    alte_pkg::OP_READ: begin
                        if (flags.pos_bad) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = alte_pkg::ST_BAD_POS;
                        end else begin
                            cmd.rd_sel = alte_pkg::RD_POS;
                            state_next = S_RDWAIT;
                        end
                    end
                    alte_pkg::OP_WRITE: begin
                        if (flags.pos_bad) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = alte_pkg::ST_BAD_POS;
                        end else begin
                            cmd.wr_sel = alte_pkg::WR_POS;
                        end
                    end
                    alte_pkg::OP_REMOVE: begin
                        if (flags.pos_bad) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = alte_pkg::ST_BAD_POS;
                        end else if (flags.rm_tail) begin
                            cmd.dec_count = 1'b1;
                        end else begin
                            cmd.idx_sel = alte_pkg::IDX_POS;
                            cmd.rd_sel  = alte_pkg::RD_POS_INC;
                            state_next  = S_SHIFT;
                        end
                    end
                    alte_pkg::OP_SEARCH: begin
                        if (!flags.empty) begin
                            cmd.idx_sel = alte_pkg::IDX_ZERO;
                            cmd.rd_sel  = alte_pkg::RD_ZERO;
                            state_next  = S_SEARCH;
                        end
                    end
                    alte_pkg::OP_POP: begin
                        if (flags.empty) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = alte_pkg::ST_EMPTY;
                        end else begin
                            cmd.rd_sel = alte_pkg::RD_LAST;
                            state_next = S_RDWAIT;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDWAIT: begin
                cmd.cap_data  = 1'b1;
                cmd.dec_count = (flags.op == alte_pkg::OP_POP);
                state_next    = S_DONE;
            end
            S_SHIFT: begin
                cmd.wr_sel  = alte_pkg::WR_SHIFT;
                cmd.rd_sel  = alte_pkg::RD_IDX_INC2;
                cmd.idx_sel = alte_pkg::IDX_INC;
                if (flags.shift_last) begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_SEARCH: begin
                cmd.rd_sel = alte_pkg::RD_IDX_INC;
                if (flags.search_hit) begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DONE;
                end else if (flags.search_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.idx_sel = alte_pkg::IDX_INC;
                end
            end
            S_DONE: begin
                if (flags.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/alte_dp.sv =====
// Datapath: entry store, count, capacity, working registers and result register.
module alte_dp #(
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic        [alte_pkg::CNT_W-1:0]      cfg_wr_data,
    input  logic        [alte_pkg::OP_W-1:0]       s_opcode,
    input  logic        [alte_pkg::POS_W-1:0]      s_position,
    input  logic signed [alte_pkg::DATA_W-1:0]     s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [alte_pkg::DATA_W-1:0]     m_data_out,
    output logic signed [alte_pkg::CNT_W-1:0]      m_found_index,
    output logic        [alte_pkg::CNT_W-1:0]      m_entry_count,
    output logic        [alte_pkg::ST_W-1:0]       m_status,
    input  alte_pkg::cmd_t                         cmd,
    output alte_pkg::flags_t                       flags
);

    localparam int SLOTS = (DEPTH < alte_pkg::MAX_SLOTS) ? DEPTH : alte_pkg::MAX_SLOTS;
    localparam int AW    = $clog2(SLOTS);
    localparam logic [alte_pkg::CNT_W-1:0] SLOTS_CNT = alte_pkg::CNT_W'(SLOTS);

    // Latched item.
    alte_pkg::opcode_t                  op_reg;
    logic [alte_pkg::POS_W-1:0]         pos_reg;
    logic [alte_pkg::DATA_W-1:0]        val_reg;

    // Control state.
    logic [alte_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [alte_pkg::CNT_W-1:0]         cap_reg, cap_next;
    logic [alte_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic                               m_valid_reg, m_valid_next;

    // Working result and output word.
    logic [alte_pkg::DATA_W-1:0]        res_data_reg, res_data_next;
    logic [alte_pkg::CNT_W-1:0]         res_found_reg, res_found_next;
    alte_pkg::status_t                  res_status_reg, res_status_next;
    logic [alte_pkg::DATA_W-1:0]        m_data_reg;
    logic [alte_pkg::CNT_W-1:0]         m_found_reg;
    logic [alte_pkg::CNT_W-1:0]         m_count_reg;
    alte_pkg::status_t                  m_status_reg;

    logic [alte_pkg::CNT_W:0]           idx_p1, idx_p2;
    logic [alte_pkg::CNT_W-1:0]         pos_p1, count_m1, limit;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr, rd_addr;
    logic [alte_pkg::DATA_W-1:0]        wr_data, rd_data;

    assign idx_p1   = {1'b0, idx_reg} + 1'b1;
    assign idx_p2   = {1'b0, idx_reg} + 2'd2;
    assign pos_p1   = {1'b0, pos_reg} + 1'b1;
    assign count_m1 = count_reg - 1'b1;
    assign limit    = (cap_reg > SLOTS_CNT) ? SLOTS_CNT : cap_reg;

    always_comb begin
        case (cmd.rd_sel)
            alte_pkg::RD_POS:      rd_addr = pos_reg[AW-1:0];
            alte_pkg::RD_LAST:     rd_addr = count_m1[AW-1:0];
            alte_pkg::RD_POS_INC:  rd_addr = pos_p1[AW-1:0];
            alte_pkg::RD_ZERO:     rd_addr = '0;
            alte_pkg::RD_IDX_INC:  rd_addr = idx_p1[AW-1:0];
            alte_pkg::RD_IDX_INC2: rd_addr = idx_p2[AW-1:0];
            default:               rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        case (cmd.wr_sel)
            alte_pkg::WR_TAIL: begin
                wr_addr = count_reg[AW-1:0];
                wr_data = val_reg;
            end
            alte_pkg::WR_POS: begin
                wr_addr = pos_reg[AW-1:0];
                wr_data = val_reg;
            end
            alte_pkg::WR_SHIFT: begin
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_data;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    alte_ram #(
        .WIDTH (alte_pkg::DATA_W),
        .DEPTH (SLOTS)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign flags.op          = op_reg;
    assign flags.full        = (count_reg >= limit);
    assign flags.pos_bad     = ({1'b0, pos_reg} >= count_reg);
    assign flags.empty       = (count_reg == '0);
    assign flags.rm_tail     = (pos_p1 >= count_reg);
    assign flags.shift_last  = (idx_p2 >= {1'b0, count_reg});
    assign flags.search_hit  = (rd_data == val_reg);
    assign flags.search_last = (idx_p1 >= {1'b0, count_reg});
    assign flags.out_free    = !m_valid_reg || m_ready;

    always_comb begin
        cap_next = cfg_wr_en ? cfg_wr_data : cap_reg;

        count_next = count_reg;
        if (cmd.inc_count) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.dec_count) begin
            count_next = count_m1;
        end

        case (cmd.idx_sel)
            alte_pkg::IDX_POS:  idx_next = {1'b0, pos_reg};
            alte_pkg::IDX_ZERO: idx_next = '0;
            alte_pkg::IDX_INC:  idx_next = idx_p1[alte_pkg::CNT_W-1:0];
            default:            idx_next = idx_reg;
        endcase

        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        if (cmd.load_item) begin
            res_data_next   = '0;
            res_found_next  = alte_pkg::NONE_IDX;
            res_status_next = alte_pkg::ST_OK;
        end
        if (cmd.set_status) begin
            res_status_next = cmd.status_code;
        end
        if (cmd.cap_data) begin
            res_data_next = rd_data;
        end
        if (cmd.set_found) begin
            res_found_next = idx_reg;
        end

        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cap_reg     <= alte_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= alte_pkg::opcode_t'(s_opcode);
            pos_reg <= s_position;
            val_reg <= s_value;
        end
        idx_reg        <= idx_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (cmd.publish) begin
            m_data_reg   <= res_data_reg;
            m_found_reg  <= res_found_reg;
            m_count_reg  <= count_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data_out    = m_data_reg;
    assign m_found_index = m_found_reg;
    assign m_entry_count = m_count_reg;
    assign m_status      = m_status_reg;

endmodule
